// File: hdl/multi_axis_stepper_period_sync_unit_assert.svh
// Assertion macros shared by the RTL.
`ifndef MULTI_AXIS_STEPPER_PERIOD_SYNC_UNIT_ASSERT_SVH
`define MULTI_AXIS_STEPPER_PERIOD_SYNC_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define MSPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define MSPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/msps_pkg.sv
package msps_pkg;

  localparam int CFG_W = 16;

  typedef enum logic [1:0] {
    REG_TICK_FLOOR      = 2'd0,
    REG_BRAKE_THRESHOLD = 2'd1,
    REG_MAX_DELTA       = 2'd2,
    REG_STOP_THRESHOLD  = 2'd3
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] TICK_FLOOR_RST = 16'd100;
  localparam logic [CFG_W-1:0] BRAKE_RST      = 16'd200;
  localparam logic [CFG_W-1:0] MAX_DELTA_RST  = 16'd50;
  localparam logic [CFG_W-1:0] STOP_RST       = 16'd5;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// File: hdl/msps_if.sv
interface msps_upd_if #(
  parameter int NUM_MOTORS = 4,
  parameter int STEP_BITS  = 24
);
  logic                            valid;
  logic                            ready;
  logic [NUM_MOTORS*STEP_BITS-1:0] delta_step;

  modport source (output valid, output delta_step, input ready);
  modport sink   (input valid, input delta_step, output ready);
endinterface

interface msps_res_if #(
  parameter int NUM_MOTORS  = 4,
  parameter int STEP_BITS   = 24,
  parameter int PERIOD_BITS = 24
);
  localparam int IW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  logic                   valid;
  logic                   ready;
  logic [IW-1:0]          motor_index;
  logic [STEP_BITS-1:0]   step_count;
  logic                   clockwise;
  logic [PERIOD_BITS-1:0] step_period;
  logic                   is_reference;
  logic                   stop_all;
  logic                   last;

  modport source (output valid, output motor_index, output step_count, output clockwise,
                  output step_period, output is_reference, output stop_all, output last,
                  input ready);
  modport sink   (input valid, input motor_index, input step_count, input clockwise,
                  input step_period, input is_reference, input stop_all, input last,
                  output ready);
endinterface

// File: hdl/msps_mul.sv
// Shift-add multiplier, one bit of a per cycle, MSB first.
module msps_mul #(
  parameter int BW = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [msps_pkg::CFG_W-1:0]    a,
  input  logic [BW-1:0]                 b,
  output logic [msps_pkg::CFG_W+BW-1:0] p,
  output msps_pkg::unit_stat_t          stat
);
  localparam int AW = msps_pkg::CFG_W;
  localparam int CW = $clog2(AW + 1);

  logic [AW-1:0] a_sh;
  logic [BW-1:0] b_q;
  logic [CW-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        a_sh      <= a;
        b_q       <= b;
        p         <= '0;
        cnt       <= CW'(AW);
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        p    <= {p[AW+BW-2:0], 1'b0} + (a_sh[AW-1] ? (AW+BW)'(b_q) : '0);
        a_sh <= {a_sh[AW-2:0], 1'b0};
        cnt  <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: hdl/msps_div.sv
// Restoring divider, one quotient bit per cycle. Divisor must be nonzero.
module msps_div #(
  parameter int NW = 40,
  parameter int DW = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NW-1:0]        num,
  input  logic [DW-1:0]        den,
  output logic [NW-1:0]        quo,
  output msps_pkg::unit_stat_t stat
);
  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  assign trial = {rem, quo[NW-1]};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        quo       <= num;
        den_q     <= den;
        rem       <= '0;
        cnt       <= CW'(NW);
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        // quo shifts the dividend out and the quotient bits in
        if (!diff[DW]) begin
          rem <= diff[DW-1:0];
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= trial[DW-1:0];
          quo <= {quo[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: hdl/multi_axis_stepper_period_sync_unit.sv
// channel  | dir | beat                         | width
// ---------+-----+------------------------------+----------------------------
// updates  | in  | delta_step, one per motor    | NUM_MOTORS*STEP_BITS
// results  | out | one beat per motor, in order | index,count,dir,period,flags
// cfg      | in  | write only, no stall         | 2 index + 16 data
//
// One update runs the ref scan and scale product, then a target per motor (the
// divider is skipped for a zero-count motor), then the limited updates (the
// multiplier and divider are skipped when nothing is limited). Both are serial
// units; the divider works on NW = 16+max(16,STEP_BITS,PERIOD_BITS) bits, and
// the receiver can stall each result beat.
// One update is in flight at a time; updates.ready is high only when idle.
// Synchronous active-high reset loads the register defaults and sets every stored
// period to the maximum. Each result beat holds until taken.
`include "multi_axis_stepper_period_sync_unit_assert.svh"

module multi_axis_stepper_period_sync_unit #(
  parameter int NUM_MOTORS  = 4,
  parameter int PERIOD_BITS = 24,
  parameter int STEP_BITS   = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [msps_pkg::CFG_W-1:0]   cfg_data,
  msps_upd_if.sink                     updates,
  msps_res_if.source                   results
);
  localparam int CW    = msps_pkg::CFG_W;
  localparam int IW    = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam int SCL_W = (STEP_BITS > CW) ? STEP_BITS : CW;
  localparam int BW    = (SCL_W > PERIOD_BITS) ? SCL_W : PERIOD_BITS;
  localparam int NW    = CW + BW;
  localparam int DW    = (STEP_BITS > PERIOD_BITS) ? STEP_BITS : PERIOD_BITS;
  localparam logic [IW-1:0]          LAST_IDX = IW'(NUM_MOTORS - 1);
  localparam logic [PERIOD_BITS-1:0] PMAX     = {PERIOD_BITS{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_MSTART, S_MWAIT, S_TSTART, S_TWAIT, S_TDELTA,
    S_LIMIT, S_USTART, S_UMWAIT, S_UDWAIT, S_UPDATE, S_EMIT
  } state_t;

  // configuration registers
  logic [CW-1:0] tick_floor, brake_threshold, max_delta_period, stop_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_floor       <= msps_pkg::TICK_FLOOR_RST;
      brake_threshold  <= msps_pkg::BRAKE_RST;
      max_delta_period <= msps_pkg::MAX_DELTA_RST;
      stop_threshold   <= msps_pkg::STOP_RST;
    end else if (cfg_we) begin
      case (msps_pkg::cfg_reg_t'(cfg_index))
        msps_pkg::REG_TICK_FLOOR:      tick_floor       <= cfg_data;
        msps_pkg::REG_BRAKE_THRESHOLD: brake_threshold  <= cfg_data;
        msps_pkg::REG_MAX_DELTA:       max_delta_period <= cfg_data;
        msps_pkg::REG_STOP_THRESHOLD:  stop_threshold   <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-motor rings; each phase rotates the rings it uses a full turn, so motor idx sits at [0]
  state_t                 state;
  logic [STEP_BITS-1:0]   cnt_q   [NUM_MOTORS];
  logic [PERIOD_BITS-1:0] per_q   [NUM_MOTORS];
  logic [PERIOD_BITS-1:0] dmag_q  [NUM_MOTORS];
  logic                   dsign_q [NUM_MOTORS];
  logic [IW-1:0]          idx;
  logic [IW-1:0]          ref_idx;
  logic [STEP_BITS-1:0]   best;
  logic [NW-1:0]          prod;
  logic [PERIOD_BITS-1:0] tgt;
  logic [PERIOD_BITS-1:0] biggest;
  logic [PERIOD_BITS-1:0] step;
  logic                   stop;
  logic                   limit;

  // shared serial units
  logic                 mul_start, div_start;
  logic [CW-1:0]        mul_a;
  logic [BW-1:0]        mul_b;
  logic [NW-1:0]        mul_p;
  logic [NW-1:0]        div_num;
  logic [DW-1:0]        div_den;
  logic [NW-1:0]        div_q;
  msps_pkg::unit_stat_t mul_st, div_st;

  msps_mul #(.BW(BW)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b), .p(mul_p), .stat(mul_st)
  );

  msps_div #(.NW(NW), .DW(DW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den), .quo(div_q),
    .stat(div_st)
  );

  // head-of-ring datapath
  logic [STEP_BITS-1:0]   head_mag;
  logic [SCL_W-1:0]       scale;
  logic [PERIOD_BITS-1:0] tgt_sat;
  logic [PERIOD_BITS:0]   d_diff;
  logic [PERIOD_BITS-1:0] d_mag;
  logic [PERIOD_BITS-1:0] new_per;

  assign head_mag = cnt_q[0][STEP_BITS-1] ? (~cnt_q[0] + 1'b1) : cnt_q[0];
  assign scale    = (SCL_W'(best) > SCL_W'(brake_threshold)) ? SCL_W'(best)
                                                             : SCL_W'(brake_threshold);
  // quotient saturates high, and never reads zero
  always_comb begin
    if (|div_q[NW-1:PERIOD_BITS]) tgt_sat = PMAX;
    else if (div_q[PERIOD_BITS-1:0] == '0) tgt_sat = PERIOD_BITS'(1);
    else tgt_sat = div_q[PERIOD_BITS-1:0];
  end
  assign d_diff  = {1'b0, tgt} - {1'b0, per_q[0]};
  assign d_mag   = d_diff[PERIOD_BITS] ? (~d_diff[PERIOD_BITS-1:0] + 1'b1)
                                       : d_diff[PERIOD_BITS-1:0];
  assign new_per = dsign_q[0] ? (per_q[0] - step) : (per_q[0] + step);

  always_comb begin
    mul_start = 1'b0;
    mul_a     = tick_floor;
    mul_b     = BW'(scale);
    div_start = 1'b0;
    div_num   = prod;
    div_den   = DW'(head_mag);
    case (state)
      S_MSTART: mul_start = 1'b1;
      S_TSTART: div_start = (head_mag != '0);
      S_USTART: begin
        mul_start = limit;
        mul_a     = max_delta_period;
        mul_b     = BW'(dmag_q[0]);
      end
      S_UMWAIT: begin
        div_start = mul_st.done;
        div_num   = mul_p;
        div_den   = DW'(biggest);
      end
      default: ;
    endcase
  end

  assign updates.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      results.valid <= 1'b0;
      idx           <= '0;
      for (int i = 0; i < NUM_MOTORS; i++) per_q[i] <= PMAX;
    end else begin
      case (state)
        S_IDLE: begin
          if (updates.valid) begin
            for (int i = 0; i < NUM_MOTORS; i++)
              cnt_q[i] <= updates.delta_step[i*STEP_BITS +: STEP_BITS];
            idx     <= '0;
            best    <= '0;
            ref_idx <= '0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          // ties go to the later motor
          if (best <= head_mag) begin
            best    <= head_mag;
            ref_idx <= idx;
          end
          for (int i = 0; i < NUM_MOTORS - 1; i++) cnt_q[i] <= cnt_q[i+1];
          cnt_q[NUM_MOTORS-1] <= cnt_q[0];
          idx <= idx + 1'b1;
          if (idx == LAST_IDX) state <= S_MSTART;
        end
        S_MSTART: state <= S_MWAIT;
        S_MWAIT: begin
          if (mul_st.done) begin
            prod    <= mul_p;
            stop    <= (SCL_W'(best) < SCL_W'(stop_threshold));
            idx     <= '0;
            biggest <= '0;
            state   <= S_TSTART;
          end
        end
        S_TSTART: begin
          if (head_mag == '0) begin
            tgt   <= PMAX;
            state <= S_TDELTA;
          end else begin
            state <= S_TWAIT;
          end
        end
        S_TWAIT: begin
          if (div_st.done) begin
            tgt   <= tgt_sat;
            state <= S_TDELTA;
          end
        end
        S_TDELTA: begin
          if (biggest <= d_mag) biggest <= d_mag;
          for (int i = 0; i < NUM_MOTORS - 1; i++) begin
            cnt_q[i]   <= cnt_q[i+1];
            per_q[i]   <= per_q[i+1];
            dmag_q[i]  <= dmag_q[i+1];
            dsign_q[i] <= dsign_q[i+1];
          end
          cnt_q[NUM_MOTORS-1]   <= cnt_q[0];
          per_q[NUM_MOTORS-1]   <= per_q[0];
          dmag_q[NUM_MOTORS-1]  <= d_mag;
          dsign_q[NUM_MOTORS-1] <= d_diff[PERIOD_BITS];
          idx <= idx + 1'b1;
          state <= (idx == LAST_IDX) ? S_LIMIT : S_TSTART;
        end
        S_LIMIT: begin
          limit <= (biggest > PERIOD_BITS'(max_delta_period));
          idx   <= '0;
          state <= S_USTART;
        end
        S_USTART: begin
          if (limit) begin
            state <= S_UMWAIT;
          end else begin
            step  <= dmag_q[0];
            state <= S_UPDATE;
          end
        end
        S_UMWAIT: if (mul_st.done) state <= S_UDWAIT;
        S_UDWAIT: begin
          // scaled step never exceeds dmag, so the low bits hold it
          if (div_st.done) begin
            step  <= div_q[PERIOD_BITS-1:0];
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          results.valid        <= 1'b1;
          results.motor_index  <= idx;
          results.step_count   <= head_mag;
          results.clockwise    <= ~cnt_q[0][STEP_BITS-1];
          results.step_period  <= new_per;
          results.is_reference <= (idx == ref_idx);
          results.stop_all     <= stop;
          results.last         <= (idx == LAST_IDX);
          for (int i = 0; i < NUM_MOTORS - 1; i++) begin
            cnt_q[i]   <= cnt_q[i+1];
            per_q[i]   <= per_q[i+1];
            dmag_q[i]  <= dmag_q[i+1];
            dsign_q[i] <= dsign_q[i+1];
          end
          cnt_q[NUM_MOTORS-1]   <= cnt_q[0];
          per_q[NUM_MOTORS-1]   <= new_per;
          dmag_q[NUM_MOTORS-1]  <= dmag_q[0];
          dsign_q[NUM_MOTORS-1] <= dsign_q[0];
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (results.ready) begin
            results.valid <= 1'b0;
            idx           <= idx + 1'b1;
            state         <= (idx == LAST_IDX) ? S_IDLE : S_USTART;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MSPS_ASSERT_NOW(a_idle_no_result, clk, rst, updates.ready, !results.valid, "result beat while idle")
  `MSPS_ASSERT_NOW(a_mul_free, clk, rst, mul_start, !mul_st.busy, "multiplier restarted while busy")
  `MSPS_ASSERT_NOW(a_div_free, clk, rst, div_start, !div_st.busy, "divider restarted while busy")
  `MSPS_ASSERT_NEXT(a_last_idle, clk, rst, results.valid && results.ready && results.last, updates.ready, "not idle after last beat")

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int NM = 4;
  localparam int SB = 24;
  localparam int PB = 24;
  localparam logic [PB-1:0] PERIOD_TOP = {PB{1'b1}};

  // one expected result beat
  typedef struct {
    logic [1:0]    motor_index;
    logic [SB-1:0] step_count;
    logic          clockwise;
    logic [PB-1:0] step_period;
    logic          is_reference;
    logic          stop_all;
    logic          last;
  } motor_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [msps_pkg::CFG_W-1:0] cfg_data = '0;

  msps_upd_if #(.NUM_MOTORS(NM), .STEP_BITS(SB)) updates ();
  msps_res_if #(.NUM_MOTORS(NM), .STEP_BITS(SB), .PERIOD_BITS(PB)) results ();

  multi_axis_stepper_period_sync_unit #(
    .NUM_MOTORS(NM), .PERIOD_BITS(PB), .STEP_BITS(SB)
  ) DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .updates(updates), .results(results)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state: shadow registers and stored periods
  logic [15:0] sh_tick_floor, sh_brake, sh_max_delta, sh_stop;
  logic [PB-1:0] sh_period [NM];

  logic [NM*SB-1:0] pending_updates [$];
  motor_beat_t expected_beats [$];
  int error_count = 0;
  bit calm = 1'b0;      // no idling in the last part
  bit hold_go = 1'b0;   // request for the long receiver hold-off
  bit hold_taken = 1'b0;
  int hold_cycles = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // work out the four result beats of one update, advancing the shadow periods
  task automatic predict_periods(input logic [NM*SB-1:0] upd);
    longint cnt [NM];
    longint unsigned mag [NM], dmag [NM];
    longint dlt [NM];
    longint unsigned refabs, scale, tgt, biggest, stp;
    int refm, big;
    bit stop, limit;
    motor_beat_t b;
    refm = 0;
    big = 0;
    for (int i = 0; i < NM; i++) begin
      cnt[i] = longint'($signed(upd[i*SB +: SB]));
      mag[i] = cnt[i] < 0 ? -cnt[i] : cnt[i];
    end
    // ties go to the higher index
    for (int i = 0; i < NM; i++) if (mag[refm] <= mag[i]) refm = i;
    refabs = mag[refm];
    stop = refabs < sh_stop;
    scale = refabs > sh_brake ? refabs : sh_brake;
    for (int i = 0; i < NM; i++) begin
      if (mag[i] == 0) tgt = PERIOD_TOP;
      else begin
        tgt = (longint'(sh_tick_floor) * scale) / mag[i];
        if (tgt > PERIOD_TOP) tgt = PERIOD_TOP;
        if (tgt == 0) tgt = 1;
      end
      dlt[i] = longint'(tgt) - longint'(sh_period[i]);
      dmag[i] = dlt[i] < 0 ? -dlt[i] : dlt[i];
    end
    for (int i = 0; i < NM; i++) if (dmag[big] <= dmag[i]) big = i;
    biggest = dmag[big];
    limit = biggest > sh_max_delta;
    for (int i = 0; i < NM; i++) begin
      stp = limit ? (dmag[i] * sh_max_delta) / biggest : dmag[i];
      if (dlt[i] < 0) sh_period[i] = sh_period[i] - PB'(stp);
      else sh_period[i] = sh_period[i] + PB'(stp);
      b.motor_index = 2'(i);
      b.step_count = SB'(mag[i]);
      b.clockwise = cnt[i] >= 0;
      b.step_period = sh_period[i];
      b.is_reference = (i == refm);
      b.stop_all = stop;
      b.last = (i == NM - 1);
      expected_beats.push_back(b);
    end
  endtask

  // driver: offers queued updates, with random idle bursts
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      updates.valid <= 1'b0;
      updates.delta_step <= '0;
    end else begin
      if (updates.valid && updates.ready) predict_periods(updates.delta_step);
      if (!updates.valid || updates.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          updates.valid <= 1'b0;
        end else if (pending_updates.size() > 0) begin
          updates.delta_step <= pending_updates.pop_front();
          updates.valid <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 17);
        end else updates.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_go && !hold_taken) begin
      hold_cycles <= 3000;
      hold_taken <= 1'b1;
    end else if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // monitor: checks each taken beat against the oldest expectation
  int recv_gap = 0;
  always @(posedge clk) begin
    motor_beat_t e;
    if (rst) results.ready <= 1'b0;
    else begin
      if (results.valid && results.ready) begin
        if (expected_beats.size() == 0) report_mismatch("unexpected beat", 1, 0);
        else begin
          e = expected_beats.pop_front();
          if (results.motor_index !== e.motor_index)
            report_mismatch("motor_index", results.motor_index, e.motor_index);
          if (results.step_count !== e.step_count)
            report_mismatch("step_count", results.step_count, e.step_count);
          if (results.clockwise !== e.clockwise)
            report_mismatch("clockwise", results.clockwise, e.clockwise);
          if (results.step_period !== e.step_period)
            report_mismatch("step_period", results.step_period, e.step_period);
          if (results.is_reference !== e.is_reference)
            report_mismatch("is_reference", results.is_reference, e.is_reference);
          if (results.stop_all !== e.stop_all)
            report_mismatch("stop_all", results.stop_all, e.stop_all);
          if (results.last !== e.last)
            report_mismatch("last", results.last, e.last);
        end
      end
      if (hold_cycles > 0) begin
        // long hold-off so the block fills and stalls its input
        results.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        results.ready <= 1'b0;
      end else begin
        results.ready <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 17);
      end
    end
  end

  task automatic write_reg(input msps_pkg::cfg_reg_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      msps_pkg::REG_TICK_FLOOR:      sh_tick_floor = val;
      msps_pkg::REG_BRAKE_THRESHOLD: sh_brake = val;
      msps_pkg::REG_MAX_DELTA:       sh_max_delta = val;
      msps_pkg::REG_STOP_THRESHOLD:  sh_stop = val;
      default: ;
    endcase
  endtask

  // every update gives results, so idle means queues empty and the driver quiet
  task automatic wait_drained();
    while (pending_updates.size() > 0 || updates.valid || expected_beats.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [SB-1:0] rand_count();
    case ($urandom_range(0, 5))
      0: return SB'($urandom_range(0, 8));
      1: return -SB'($urandom_range(0, 8));
      2: return SB'($urandom_range(0, 400)) ^ {SB{$urandom_range(0, 1) == 1}};
      3: return {1'b0, {(SB-1){1'b1}}} - SB'($urandom_range(0, 3));
      4: return {1'b1, {(SB-1){1'b0}}} + SB'($urandom_range(0, 3));
      default: return SB'($urandom());
    endcase
  endfunction

  task automatic queue_random(input int n);
    logic [NM*SB-1:0] u;
    repeat (n) begin
      for (int m = 0; m < NM; m++) u[m*SB +: SB] = rand_count();
      pending_updates.push_back(u);
    end
  endtask

  task automatic queue_same(input logic [SB-1:0] a, b, c, d);
    pending_updates.push_back({d, c, b, a});
  endtask

  localparam logic [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

  initial begin
    sh_tick_floor = msps_pkg::TICK_FLOOR_RST;
    sh_brake = msps_pkg::BRAKE_RST;
    sh_max_delta = msps_pkg::MAX_DELTA_RST;
    sh_stop = msps_pkg::STOP_RST;
    for (int i = 0; i < NM; i++) sh_period[i] = PERIOD_TOP;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: all zero, extremes, ties, stop, small counts
    queue_same('0, '0, '0, '0);
    queue_same(SMAX, SMIN, 24'd1, -24'd1);
    queue_same(24'd7, -24'd7, 24'd7, 24'd3);
    queue_same(24'd2, 24'd1, '0, -24'd4);
    queue_same(24'd1000, 24'd500, -24'd250, 24'd1);
    queue_same(SMIN, SMIN, SMIN, SMIN);
    queue_same(-24'd1, 24'd0, 24'd3, 24'h555555);
    queue_same(24'h2AAAAA, -24'h2AAAAA, 24'd100, 24'd199);
    wait_drained();

    // top max delta, zero tick floor, zero stop threshold
    write_reg(msps_pkg::REG_MAX_DELTA, 16'hFFFF);
    write_reg(msps_pkg::REG_TICK_FLOOR, 16'd0);
    write_reg(msps_pkg::REG_STOP_THRESHOLD, 16'd0);
    queue_same(24'd5, 24'd9, '0, -24'd9);
    queue_same(24'd300, -24'd20, 24'd1, SMAX);
    wait_drained();

    // extreme settings: large periods, saturation, zero max delta
    write_reg(msps_pkg::REG_TICK_FLOOR, 16'hFFFF);
    write_reg(msps_pkg::REG_BRAKE_THRESHOLD, 16'hFFFF);
    write_reg(msps_pkg::REG_STOP_THRESHOLD, 16'hFFFF);
    write_reg(msps_pkg::REG_MAX_DELTA, 16'd0);
    queue_same(24'd1, SMAX, -24'd2, 24'd70000);
    queue_same(SMIN, 24'd1, '0, 24'd3);
    wait_drained();

    write_reg(msps_pkg::REG_MAX_DELTA, 16'd1);
    write_reg(msps_pkg::REG_BRAKE_THRESHOLD, 16'd1);
    write_reg(msps_pkg::REG_TICK_FLOOR, 16'd1);
    queue_same(SMAX, 24'd1, 24'd2, -24'd3);
    queue_random(40);
    wait_drained();

    // pressure: receiver holds off while the sender keeps offering
    write_reg(msps_pkg::REG_TICK_FLOOR, 16'd250);
    write_reg(msps_pkg::REG_BRAKE_THRESHOLD, 16'd64);
    write_reg(msps_pkg::REG_MAX_DELTA, 16'd4000);
    write_reg(msps_pkg::REG_STOP_THRESHOLD, 16'd20);
    @(posedge clk);
    hold_go = 1'b1;
    queue_random(80);
    wait_drained();

    // reset values again, then a calm tail with no idling
    write_reg(msps_pkg::REG_TICK_FLOOR, msps_pkg::TICK_FLOOR_RST);
    write_reg(msps_pkg::REG_BRAKE_THRESHOLD, msps_pkg::BRAKE_RST);
    write_reg(msps_pkg::REG_MAX_DELTA, msps_pkg::MAX_DELTA_RST);
    write_reg(msps_pkg::REG_STOP_THRESHOLD, msps_pkg::STOP_RST);
    queue_random(117);
    while (pending_updates.size() > 30) @(posedge clk);
    calm = 1'b1;
    wait_drained();
    repeat (400) @(posedge clk);

    if (error_count == 0 && expected_beats.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // timeout for the 250 updates with their stalls, gaps and holds
  initial begin
    #40ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
